>>> rtl/core/rdpe_pkg.sv
// Package with the types and constants shared by the reversible deque pop engine.
`default_nettype none

package rdpe_pkg;

   // Capacity of the element store and the widths used with it.
   localparam int DEPTH = 64;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int IDX_W = 7;
   localparam int DATA_W = 32;

   typedef enum logic [1:0] {
      OP_LOAD    = 2'd0,
      OP_REVERSE = 2'd1,
      OP_DELETE  = 2'd2,
      OP_FINISH  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_ELEMENT = 2'd0,
      ST_EMPTY   = 2'd1,
      ST_ERROR   = 2'd2
   } status_type;

   typedef enum logic {
      FSM_IDLE = 1'b0,
      FSM_WALK = 1'b1
   } fsm_type;

   typedef struct packed {
      op_type                    operation;
      logic signed [DATA_W-1:0]  value;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0]  element;
      status_type                status;
      logic                      last;
   } rsp_type;

endpackage

`default_nettype wire

>>> rtl/core/reversible_deque_pop_engine.sv
// Top level of the reversible deque pop engine: command handling, element store and emit walk.
`default_nettype none

// The engine holds a list of up to 64 signed 32-bit elements in a single-port-read,
// single-port-write memory. Each request word carries an operation: load appends an
// element until the first reverse or delete of a case, reverse flips the logical order
// by swapping the front and back indices, delete drops the current front element (on
// an empty list it sets a sticky error that makes later reverse and delete commands
// no-ops), and finish emits the list. Load, reverse and delete never stall unless an
// emit is still draining. Finish answers with one response word per remaining element
// in logical order, the final one marked last, or with a single empty or error word;
// a walk delivers one word per cycle while rsp_stall is low, limited by the single
// memory read port, and holds req_stall high until the walk ends and the fetch stage
// drains. After finish the case state returns to its reset values; the store itself
// is not cleared, since only freshly loaded entries are ever read. Loads are blocked
// during a walk, so a read never meets a write to the same entry. Response words pass
// through a fetch stage and an output register, so commands of the next case are
// accepted while the last word still waits to be taken.

module reversible_deque_pop_engine (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire rdpe_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output rdpe_pkg::rsp_type      rsp_data
);

   // Element store and its registered read data.
   logic [rdpe_pkg::DATA_W-1:0] store_mem [rdpe_pkg::DEPTH];
   logic [rdpe_pkg::DATA_W-1:0] mem_q_ff;

   // Case state.
   logic [rdpe_pkg::IDX_W-1:0]  front_ff, front_in;
   logic [rdpe_pkg::IDX_W-1:0]  back_ff, back_in;
   logic                        reversed_ff, reversed_in;
   logic                        error_ff, error_in;
   logic                        closed_ff, closed_in;

   // Emit walk.
   rdpe_pkg::fsm_type           fsm_ff, fsm_in;
   logic [rdpe_pkg::ADDR_W-1:0] walk_addr_ff, walk_addr_in;
   logic [rdpe_pkg::ADDR_W-1:0] walk_end_ff, walk_end_in;
   logic                        walk_down_ff, walk_down_in;

   // Fetch stage between the memory and the output register.
   logic                        fetch_valid_ff, fetch_valid_in;
   rdpe_pkg::status_type        fetch_status_ff, fetch_status_in;
   logic                        fetch_last_ff, fetch_last_in;

   // Output register.
   logic                        rsp_valid_ff, rsp_valid_in;
   rdpe_pkg::rsp_type           rsp_ff, rsp_in;

   logic                        req_take;
   logic                        load_write;
   logic                        fetch_move;
   logic                        fetch_free;
   logic                        rd_en;
   logic                        walk_last;
   logic                        finish_walk;
   logic                        finish_status;
   rdpe_pkg::status_type        finish_code;

   function automatic logic [rdpe_pkg::ADDR_W-1:0] back_in_minus_one(
      input logic [rdpe_pkg::IDX_W-1:0] idx
   );
      logic [rdpe_pkg::IDX_W-1:0] dec;
      dec = idx - 1'b1;
      return dec[rdpe_pkg::ADDR_W-1:0];
   endfunction

   // A new word is refused while a walk runs or while the fetch stage is still occupied,
   // because a finish may need that stage straight away.
   assign req_stall = (fsm_ff == rdpe_pkg::FSM_WALK) || fetch_valid_ff;
   assign req_take  = req_valid && !req_stall;

   assign fetch_move = fetch_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign fetch_free = !fetch_valid_ff || fetch_move;
   assign walk_last  = (walk_addr_ff == walk_end_ff);

   assign load_write = req_take && (req_data.operation == rdpe_pkg::OP_LOAD) && !closed_ff
                       && (back_ff < rdpe_pkg::IDX_W'(rdpe_pkg::DEPTH));

   // Case state update for each accepted command.
   always_comb begin
      front_in      = front_ff;
      back_in       = back_ff;
      reversed_in   = reversed_ff;
      error_in      = error_ff;
      closed_in     = closed_ff;
      walk_addr_in  = walk_addr_ff;
      walk_end_in   = walk_end_ff;
      walk_down_in  = walk_down_ff;
      finish_walk   = 1'b0;
      finish_status = 1'b0;
      finish_code   = rdpe_pkg::ST_EMPTY;
      if (req_take) begin
         unique case (req_data.operation)
            rdpe_pkg::OP_LOAD: begin
               if (load_write) begin
                  back_in = back_ff + 1'b1;
               end
            end
            rdpe_pkg::OP_REVERSE: begin
               closed_in = 1'b1;
               if (!error_ff) begin
                  front_in    = back_ff;
                  back_in     = front_ff;
                  reversed_in = !reversed_ff;
               end
            end
            rdpe_pkg::OP_DELETE: begin
               closed_in = 1'b1;
               if (!error_ff) begin
                  priority if (front_ff < back_ff) begin
                     front_in = front_ff + 1'b1;
                  end else if (front_ff > back_ff) begin
                     front_in = front_ff - 1'b1;
                  end else begin
                     error_in = 1'b1;
                  end
               end
            end
            rdpe_pkg::OP_FINISH: begin
               priority if (error_ff) begin
                  finish_status = 1'b1;
                  finish_code   = rdpe_pkg::ST_ERROR;
               end else if (front_ff == back_ff) begin
                  finish_status = 1'b1;
                  finish_code   = rdpe_pkg::ST_EMPTY;
               end else if (front_ff < back_ff) begin
                  // Ascending: from the front up to the entry below the back.
                  finish_walk  = 1'b1;
                  walk_down_in = 1'b0;
                  walk_addr_in = front_ff[rdpe_pkg::ADDR_W-1:0];
                  walk_end_in  = back_in_minus_one(back_ff);
               end else begin
                  // Descending: from the entry below the front down to the back.
                  finish_walk  = 1'b1;
                  walk_down_in = 1'b1;
                  walk_addr_in = back_in_minus_one(front_ff);
                  walk_end_in  = back_ff[rdpe_pkg::ADDR_W-1:0];
               end
               front_in    = '0;
               back_in     = '0;
               reversed_in = 1'b0;
               error_in    = 1'b0;
               closed_in   = 1'b0;
            end
            default: begin
            end
         endcase
      end
      if (rd_en) begin
         walk_addr_in = walk_down_ff ? walk_addr_ff - 1'b1 : walk_addr_ff + 1'b1;
      end
   end

   // Walk sequencer: next state.
   always_comb begin
      fsm_in = fsm_ff;
      unique case (fsm_ff)
         rdpe_pkg::FSM_IDLE: begin
            if (finish_walk) begin
               fsm_in = rdpe_pkg::FSM_WALK;
            end
         end
         rdpe_pkg::FSM_WALK: begin
            if (rd_en && walk_last) begin
               fsm_in = rdpe_pkg::FSM_IDLE;
            end
         end
         default: begin
            fsm_in = rdpe_pkg::FSM_IDLE;
         end
      endcase
   end

   // Walk sequencer: outputs. A read is issued only when the fetch stage will be free.
   always_comb begin
      rd_en = 1'b0;
      unique case (fsm_ff)
         rdpe_pkg::FSM_IDLE: begin
            rd_en = 1'b0;
         end
         rdpe_pkg::FSM_WALK: begin
            rd_en = fetch_free;
         end
         default: begin
            rd_en = 1'b0;
         end
      endcase
   end

   // Fetch stage and output register.
   always_comb begin
      fetch_valid_in  = fetch_valid_ff;
      fetch_status_in = fetch_status_ff;
      fetch_last_in   = fetch_last_ff;
      if (fetch_move) begin
         fetch_valid_in = 1'b0;
      end
      if (rd_en) begin
         fetch_valid_in  = 1'b1;
         fetch_status_in = rdpe_pkg::ST_ELEMENT;
         fetch_last_in   = walk_last;
      end else if (finish_status) begin
         fetch_valid_in  = 1'b1;
         fetch_status_in = finish_code;
         fetch_last_in   = 1'b1;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (fetch_move) begin
         rsp_valid_in   = 1'b1;
         rsp_in.element = (fetch_status_ff == rdpe_pkg::ST_ELEMENT) ? mem_q_ff : '0;
         rsp_in.status  = fetch_status_ff;
         rsp_in.last    = fetch_last_ff;
      end
   end

   // Element store: one write port for loads, one registered read port for the walk.
   always_ff @(posedge clock) begin
      if (load_write) begin
         store_mem[back_ff[rdpe_pkg::ADDR_W-1:0]] <= req_data.value;
      end
      if (rd_en) begin
         mem_q_ff <= store_mem[walk_addr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff       <= '0;
         back_ff        <= '0;
         reversed_ff    <= 1'b0;
         error_ff       <= 1'b0;
         closed_ff      <= 1'b0;
         fsm_ff         <= rdpe_pkg::FSM_IDLE;
         fetch_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         front_ff       <= front_in;
         back_ff        <= back_in;
         reversed_ff    <= reversed_in;
         error_ff       <= error_in;
         closed_ff      <= closed_in;
         fsm_ff         <= fsm_in;
         fetch_valid_ff <= fetch_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      walk_addr_ff    <= walk_addr_in;
      walk_end_ff     <= walk_end_in;
      walk_down_ff    <= walk_down_in;
      fetch_status_ff <= fetch_status_in;
      fetch_last_ff   <= fetch_last_in;
      rsp_ff          <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire
